FILE: rtl/ttpwa_pkg.sv
// Shared types, constants and arithmetic helpers of the task time profiler.
package ttpwa_pkg;

    localparam int NUM_TASKS_DEF = 16;

    localparam logic [31:0] FREQ_RESET  = 32'd1000;
    localparam logic [31:0] AVG_WARMUP  = 32'd4;

    // long division of the average numerators, 16 bits of quotient per step
    localparam int CHUNK_W   = 16;
    localparam int NUM_W     = 48;
    localparam int DIV_STEPS = NUM_W / CHUNK_W;
    localparam int DSTEP_W   = CHUNK_W + 4;

    localparam logic [3:0]  DIV_TIME  = 4'd10;
    localparam logic [3:0]  DIV_COUNT = 4'd5;
    localparam logic [17:0] RECIP_TIME  = 18'((1 << DSTEP_W) / 10);
    localparam logic [17:0] RECIP_COUNT = 18'((1 << DSTEP_W) / 5);

    typedef enum logic [1:0] {
        CMD_SWITCH  = 2'd0,
        CMD_READ    = 2'd1,
        CMD_RESTART = 2'd2
    } t_cmd;

    // one task entry of the statistics memory
    typedef struct packed {
        logic [39:0] cur_time;
        logic [31:0] cur_count;
        logic [39:0] prev_time;
        logic [31:0] prev_count;
        logic [39:0] avg_time;
        logic [31:0] avg_count;
    } t_entry;

    typedef struct packed {
        logic [CHUNK_W-1:0] q;
        logic [3:0]         r;
    } t_dstep;

    // One step of long division by a small constant: reciprocal estimate,
    // then a single correction.
    function automatic t_dstep div_step(input logic [DSTEP_W-1:0] v,
                                        input logic [3:0] d,
                                        input logic [17:0] m);
        logic [37:0]         prod;
        logic [CHUNK_W-1:0]  q;
        logic [DSTEP_W-1:0]  r;
        t_dstep              res;
        prod = 38'(v) * 38'(m);
        q    = prod[DSTEP_W+CHUNK_W-1:DSTEP_W];
        r    = v - DSTEP_W'(q) * DSTEP_W'(d);
        if (r >= DSTEP_W'(d)) begin
            q = q + 1'b1;
            r = r - DSTEP_W'(d);
        end
        res.q = q;
        res.r = r[3:0];
        return res;
    endfunction

endpackage

FILE: rtl/ttpwa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ttpwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/task_time_profiler_window_average.sv
// Top level of the per-task time profiler with windowed averages.
//
// Usage: one command per transfer on the input channel (i_valid/o_ready):
// switch task, read one task's statistics, or restart. Every command gives
// exactly one result transfer on the output channel (o_valid/i_ready).
// Registers frequency (offset 0) and window_seconds (offset 4) sit on the
// APB-style port; change them only while the block is idle.
// Flow: restart, an ignored switch and an unknown command go straight to
// the result; a read loads the task's entry first; a switch checks the
// window, charges the outgoing task and, if it has an entry, writes it back.
// A switch that closes a window walks every task entry of the statistics
// memory first (read, load, three division steps of the averages, write
// back), skipping the division during the first three windows, which copy
// the current values without dividing. One command is in flight at a time:
// the next one can be accepted in the same cycle the result is offered.
// Reset (and the restart command) clears all task entries at once through
// per-entry valid bits; no clearing pass is needed.
// A finished result waits in an output register while the next command is
// accepted; the sequencer holds in its final state, with the input blocked,
// only when that register is still full and the receiver stalls.
module task_time_profiler_window_average #(
    parameter int NUM_TASKS = ttpwa_pkg::NUM_TASKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // command channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [3:0]  i_task_req,
    input  logic [31:0] i_timestamp,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_inactive,
    output logic        o_rolled_over,
    output logic [3:0]  o_ended_task,
    output logic [31:0] o_elapsed,
    output logic [39:0] o_window_time,
    output logic [31:0] o_window_count,
    output logic [39:0] o_average_time,
    output logic [31:0] o_average_count,
    output logic [31:0] o_windows_done
);

    localparam int IDX_W = $clog2(NUM_TASKS);
    localparam int ENT_W = $bits(ttpwa_pkg::t_entry);
    localparam logic REG_FREQUENCY      = 1'b0;
    localparam logic REG_WINDOW_SECONDS = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK,
        ST_SW_RD,
        ST_SW_LD,
        ST_SW_DIV,
        ST_SW_WR,
        ST_CHG,
        ST_CH_LD,
        ST_RD_LD,
        ST_DONE
    } t_state;

    // ---------------------------------------------------------------- registers
    t_state             r_state,    n_state;
    logic [31:0]        r_freq,     n_freq;
    logic [11:0]        r_wsec,     n_wsec;
    logic [43:0]        r_win_len,  n_win_len;
    logic [NUM_TASKS-1:0] r_valid,  n_valid;
    logic [39:0]        r_wtotal,   n_wtotal;
    logic [31:0]        r_stamp,    n_stamp;
    logic [3:0]         r_cur_task, n_cur_task;
    logic [31:0]        r_wcnt,     n_wcnt;
    logic               r_rd_vld,   n_rd_vld;
    // latched command
    logic [3:0]         r_task,     n_task;
    logic [31:0]        r_ts,       n_ts;
    // sweep and division
    logic [IDX_W-1:0]   r_idx,      n_idx;
    logic [1:0]         r_step,     n_step;
    logic [ttpwa_pkg::NUM_W-1:0] r_num_t, n_num_t;
    logic [ttpwa_pkg::NUM_W-1:0] r_num_c, n_num_c;
    logic [3:0]         r_rem_t,    n_rem_t;
    logic [3:0]         r_rem_c,    n_rem_c;
    logic [39:0]        r_cur_t,    n_cur_t;
    logic [31:0]        r_cur_c,    n_cur_c;
    // result under construction
    logic               r_res_inactive, n_res_inactive;
    logic               r_res_rolled,   n_res_rolled;
    logic [3:0]         r_res_ended,    n_res_ended;
    logic [31:0]        r_res_elapsed,  n_res_elapsed;
    logic [39:0]        r_res_wtime,    n_res_wtime;
    logic [31:0]        r_res_wcount,   n_res_wcount;
    logic [39:0]        r_res_atime,    n_res_atime;
    logic [31:0]        r_res_acount,   n_res_acount;
    logic [31:0]        r_res_wdone,    n_res_wdone;
    // output register
    logic               r_out_valid,    n_out_valid;
    logic               r_out_inactive, n_out_inactive;
    logic               r_out_rolled,   n_out_rolled;
    logic [3:0]         r_out_ended,    n_out_ended;
    logic [31:0]        r_out_elapsed,  n_out_elapsed;
    logic [39:0]        r_out_wtime,    n_out_wtime;
    logic [31:0]        r_out_wcount,   n_out_wcount;
    logic [39:0]        r_out_atime,    n_out_atime;
    logic [31:0]        r_out_acount,   n_out_acount;
    logic [31:0]        r_out_wdone,    n_out_wdone;

    // ------------------------------------------------------------ statistics RAM
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [IDX_W-1:0]   ram_raddr;
    ttpwa_pkg::t_entry  ram_wdata;
    logic [ENT_W-1:0]   ram_q;
    ttpwa_pkg::t_entry  rd_ent;

    ttpwa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_TASKS)
    ) u_stats_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // an entry never written since reset or restart reads as zero
    assign rd_ent = r_rd_vld ? ttpwa_pkg::t_entry'(ram_q) : '0;

    // ------------------------------------------------------------- datapath
    logic               cfg_wr;
    logic               req_in_range;
    logic               cur_in_range;
    logic [31:0]        elapsed;
    logic [40:0]        wtotal_sum;
    logic [40:0]        ctime_sum;
    logic [39:0]        clamp_prev;
    logic [ttpwa_pkg::NUM_W-1:0] num_t_new;
    logic [ttpwa_pkg::NUM_W-1:0] num_c_full;
    ttpwa_pkg::t_dstep  ds_t;
    ttpwa_pkg::t_dstep  ds_c;
    logic               sweep_last;

    assign cfg_wr       = psel && penable && pwrite && pready;
    assign req_in_range = 32'(i_task_req) < NUM_TASKS;
    assign cur_in_range = 32'(r_cur_task) < NUM_TASKS;
    assign elapsed      = r_ts - r_stamp;
    assign wtotal_sum   = 41'(r_wtotal) + 41'(elapsed);
    assign ctime_sum    = 41'(rd_ent.cur_time) + 41'(r_res_elapsed);
    assign sweep_last   = (r_idx == IDX_W'(NUM_TASKS - 1));

    // clamp the previous window time to the tick rate before averaging
    assign clamp_prev = (rd_ent.prev_time > 40'(r_freq)) ? 40'(r_freq) : rd_ent.prev_time;
    // (avg*90 + p*10)/100 == (9*avg + p)/10
    assign num_t_new  = (48'(rd_ent.avg_time) << 3) + 48'(rd_ent.avg_time) + 48'(clamp_prev);
    // (avg*95 + prev*10)/100 == ((19*avg + 2*prev)/4)/5
    assign num_c_full = (48'(rd_ent.avg_count) << 4) + (48'(rd_ent.avg_count) << 1)
                      + 48'(rd_ent.avg_count) + (48'(rd_ent.prev_count) << 1);

    assign ds_t = ttpwa_pkg::div_step({r_rem_t, r_num_t[ttpwa_pkg::NUM_W-1 -: ttpwa_pkg::CHUNK_W]},
                                      ttpwa_pkg::DIV_TIME, ttpwa_pkg::RECIP_TIME);
    assign ds_c = ttpwa_pkg::div_step({r_rem_c, r_num_c[ttpwa_pkg::NUM_W-1 -: ttpwa_pkg::CHUNK_W]},
                                      ttpwa_pkg::DIV_COUNT, ttpwa_pkg::RECIP_COUNT);

    // ---------------------------------------------------------- next state
    always_comb begin
        n_state        = r_state;
        n_freq         = r_freq;
        n_wsec         = r_wsec;
        n_win_len      = 44'(r_freq) * 44'(r_wsec);
        n_valid        = r_valid;
        n_wtotal       = r_wtotal;
        n_stamp        = r_stamp;
        n_cur_task     = r_cur_task;
        n_wcnt         = r_wcnt;
        n_task         = r_task;
        n_ts           = r_ts;
        n_idx          = r_idx;
        n_step         = r_step;
        n_num_t        = r_num_t;
        n_num_c        = r_num_c;
        n_rem_t        = r_rem_t;
        n_rem_c        = r_rem_c;
        n_cur_t        = r_cur_t;
        n_cur_c        = r_cur_c;
        n_res_inactive = r_res_inactive;
        n_res_rolled   = r_res_rolled;
        n_res_ended    = r_res_ended;
        n_res_elapsed  = r_res_elapsed;
        n_res_wtime    = r_res_wtime;
        n_res_wcount   = r_res_wcount;
        n_res_atime    = r_res_atime;
        n_res_acount   = r_res_acount;
        n_res_wdone    = r_res_wdone;
        n_out_valid    = r_out_valid;
        n_out_inactive = r_out_inactive;
        n_out_rolled   = r_out_rolled;
        n_out_ended    = r_out_ended;
        n_out_elapsed  = r_out_elapsed;
        n_out_wtime    = r_out_wtime;
        n_out_wcount   = r_out_wcount;
        n_out_atime    = r_out_atime;
        n_out_acount   = r_out_acount;
        n_out_wdone    = r_out_wdone;
        ram_we         = 1'b0;
        ram_waddr      = r_idx;
        ram_wdata      = '0;
        ram_raddr      = r_idx;

        // configuration writes
        if (cfg_wr) begin
            unique case (paddr[2])
                REG_FREQUENCY:      n_freq = pwdata;
                REG_WINDOW_SECONDS: n_wsec = pwdata[11:0];
                default:            n_freq = r_freq;
            endcase
        end

        // retire the output register once the receiver takes it
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                ram_raddr = IDX_W'(i_task_req);
                if (i_valid) begin
                    n_task         = i_task_req;
                    n_ts           = i_timestamp;
                    n_res_inactive = 1'b0;
                    n_res_rolled   = 1'b0;
                    n_res_ended    = '0;
                    n_res_elapsed  = '0;
                    n_res_wtime    = '0;
                    n_res_wcount   = '0;
                    n_res_atime    = '0;
                    n_res_acount   = '0;
                    n_res_wdone    = '0;
                    unique case (ttpwa_pkg::t_cmd'(i_command))
                        ttpwa_pkg::CMD_SWITCH: begin
                            if (r_wsec == '0) begin
                                n_res_inactive = 1'b1;
                                n_state        = ST_DONE;
                            end else begin
                                n_state = ST_CHK;
                            end
                        end
                        ttpwa_pkg::CMD_READ: begin
                            n_res_wdone = r_wcnt;
                            n_state     = req_in_range ? ST_RD_LD : ST_DONE;
                        end
                        ttpwa_pkg::CMD_RESTART: begin
                            n_valid    = '0;
                            n_wtotal   = '0;
                            n_cur_task = 4'd1;
                            n_wcnt     = 32'd1;
                            n_stamp    = i_timestamp;
                            n_state    = ST_DONE;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end

            ST_CHK: begin
                if (44'(r_wtotal) >= r_win_len) begin
                    n_res_rolled = 1'b1;
                    n_idx        = '0;
                    n_state      = ST_SW_RD;
                end else begin
                    n_state = ST_CHG;
                end
            end

            ST_SW_RD: begin
                ram_raddr = r_idx;
                n_state   = ST_SW_LD;
            end

            ST_SW_LD: begin
                n_cur_t = rd_ent.cur_time;
                n_cur_c = rd_ent.cur_count;
                if (r_wcnt < ttpwa_pkg::AVG_WARMUP) begin
                    n_num_t = 48'(rd_ent.cur_time);
                    n_num_c = 48'(rd_ent.cur_count);
                    n_state = ST_SW_WR;
                end else begin
                    n_num_t = num_t_new;
                    n_num_c = num_c_full >> 2;
                    n_rem_t = '0;
                    n_rem_c = '0;
                    n_step  = '0;
                    n_state = ST_SW_DIV;
                end
            end

            ST_SW_DIV: begin
                n_num_t = {r_num_t[ttpwa_pkg::NUM_W-ttpwa_pkg::CHUNK_W-1:0], ds_t.q};
                n_num_c = {r_num_c[ttpwa_pkg::NUM_W-ttpwa_pkg::CHUNK_W-1:0], ds_c.q};
                n_rem_t = ds_t.r;
                n_rem_c = ds_c.r;
                n_step  = r_step + 1'b1;
                if (r_step == 2'(ttpwa_pkg::DIV_STEPS - 1)) begin
                    n_state = ST_SW_WR;
                end
            end

            ST_SW_WR: begin
                ram_we               = 1'b1;
                ram_waddr            = r_idx;
                ram_wdata.cur_time   = '0;
                ram_wdata.cur_count  = '0;
                ram_wdata.prev_time  = r_cur_t;
                ram_wdata.prev_count = r_cur_c;
                ram_wdata.avg_time   = r_num_t[39:0];
                ram_wdata.avg_count  = (|r_num_c[ttpwa_pkg::NUM_W-1:32]) ? '1 : r_num_c[31:0];
                n_valid[r_idx]       = 1'b1;
                if (sweep_last) begin
                    n_wcnt   = (r_wcnt == '1) ? r_wcnt : r_wcnt + 1'b1;
                    n_wtotal = '0;
                    n_state  = ST_CHG;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_SW_RD;
                end
            end

            ST_CHG: begin
                // charge the outgoing task; read its entry if it has one
                ram_raddr     = IDX_W'(r_cur_task);
                n_wtotal      = wtotal_sum[40] ? '1 : wtotal_sum[39:0];
                n_stamp       = r_ts;
                n_cur_task    = r_task;
                n_res_ended   = r_cur_task;
                n_res_elapsed = elapsed;
                n_state       = cur_in_range ? ST_CH_LD : ST_DONE;
            end

            ST_CH_LD: begin
                ram_we              = 1'b1;
                ram_waddr           = IDX_W'(r_res_ended);
                ram_wdata           = rd_ent;
                ram_wdata.cur_time  = ctime_sum[40] ? '1 : ctime_sum[39:0];
                ram_wdata.cur_count = (rd_ent.cur_count == '1) ? rd_ent.cur_count
                                                               : rd_ent.cur_count + 1'b1;
                n_valid[IDX_W'(r_res_ended)] = 1'b1;
                n_state             = ST_DONE;
            end

            ST_RD_LD: begin
                n_res_wtime  = rd_ent.prev_time;
                n_res_wcount = rd_ent.prev_count;
                n_res_atime  = rd_ent.avg_time;
                n_res_acount = rd_ent.avg_count;
                n_state      = ST_DONE;
            end

            ST_DONE: begin
                // hand over once the output register is free
                if (!r_out_valid || i_ready) begin
                    n_out_valid    = 1'b1;
                    n_out_inactive = r_res_inactive;
                    n_out_rolled   = r_res_rolled;
                    n_out_ended    = r_res_ended;
                    n_out_elapsed  = r_res_elapsed;
                    n_out_wtime    = r_res_wtime;
                    n_out_wcount   = r_res_wcount;
                    n_out_atime    = r_res_atime;
                    n_out_acount   = r_res_acount;
                    n_out_wdone    = r_res_wdone;
                    n_state        = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // sample the valid bit of the entry being read
        n_rd_vld = (32'(ram_raddr) < NUM_TASKS) && r_valid[ram_raddr];
    end

    // --------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_freq      <= ttpwa_pkg::FREQ_RESET;
            r_wsec      <= '0;
            r_valid     <= '0;
            r_wtotal    <= '0;
            r_stamp     <= '0;
            r_cur_task  <= 4'd1;
            r_wcnt      <= 32'd1;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_freq      <= n_freq;
            r_wsec      <= n_wsec;
            r_valid     <= n_valid;
            r_wtotal    <= n_wtotal;
            r_stamp     <= n_stamp;
            r_cur_task  <= n_cur_task;
            r_wcnt      <= n_wcnt;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
        r_win_len      <= n_win_len;
        r_task         <= n_task;
        r_ts           <= n_ts;
        r_idx          <= n_idx;
        r_step         <= n_step;
        r_num_t        <= n_num_t;
        r_num_c        <= n_num_c;
        r_rem_t        <= n_rem_t;
        r_rem_c        <= n_rem_c;
        r_cur_t        <= n_cur_t;
        r_cur_c        <= n_cur_c;
        r_res_inactive <= n_res_inactive;
        r_res_rolled   <= n_res_rolled;
        r_res_ended    <= n_res_ended;
        r_res_elapsed  <= n_res_elapsed;
        r_res_wtime    <= n_res_wtime;
        r_res_wcount   <= n_res_wcount;
        r_res_atime    <= n_res_atime;
        r_res_acount   <= n_res_acount;
        r_res_wdone    <= n_res_wdone;
        r_out_inactive <= n_out_inactive;
        r_out_rolled   <= n_out_rolled;
        r_out_ended    <= n_out_ended;
        r_out_elapsed  <= n_out_elapsed;
        r_out_wtime    <= n_out_wtime;
        r_out_wcount   <= n_out_wcount;
        r_out_atime    <= n_out_atime;
        r_out_acount   <= n_out_acount;
        r_out_wdone    <= n_out_wdone;
    end

    // ----------------------------------------------------------------- outputs
    assign pready          = 1'b1;
    assign prdata          = (paddr[2] == REG_WINDOW_SECONDS) ? 32'(r_wsec) : r_freq;
    assign o_ready         = (r_state == ST_IDLE);
    assign o_valid         = r_out_valid;
    assign o_inactive      = r_out_inactive;
    assign o_rolled_over   = r_out_rolled;
    assign o_ended_task    = r_out_ended;
    assign o_elapsed       = r_out_elapsed;
    assign o_window_time   = r_out_wtime;
    assign o_window_count  = r_out_wcount;
    assign o_average_time  = r_out_atime;
    assign o_average_count = r_out_acount;
    assign o_windows_done  = r_out_wdone;

    // -------------------------------------------------------------- assertions
    // an ignored switch never closes a window
    a_inactive_no_roll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_inactive && o_rolled_over))
        else $error("ignored switch reported a window close");

    // a finished sweep leaves every task entry written
    a_sweep_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SW_WR && sweep_last) |=> (r_valid == '1))
        else $error("window close left task entries unwritten");

    // a closed window restarts its total before the charge
    a_sweep_clears_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SW_WR && sweep_last) |=> (r_wtotal == '0 && r_state == ST_CHG))
        else $error("window total not cleared after window close");

    // the window counter starts at one and saturates, so it is never zero
    a_wcnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wcnt != '0)
        else $error("window counter reached zero");

endmodule
